// ===== rtl/quadtree_node_index_for_box_macros.svh =====
// Assertion macros for the quadtree node lookup RTL.
`ifndef QUADTREE_NODE_INDEX_FOR_BOX_MACROS_SVH
`define QUADTREE_NODE_INDEX_FOR_BOX_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define QNIB_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Checks that a condition implies an expression in the same cycle.
`define QNIB_ASSERT_IMPLY(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

`endif

// ===== rtl/qnib_pkg.sv =====
// Package with the types and constants of the quadtree node lookup block.
package qnib_pkg;

   localparam int COORD_BITS          = 24;
   localparam int WORLD_BITS          = 23;
   localparam int TAG_BITS            = 16;
   localparam int NODE_INDEX_BITS     = 7;
   localparam int NODE_LEVEL_BITS     = 2;
   localparam int TREE_LEVELS_DEFAULT = 3;

   localparam logic [WORLD_BITS-1:0] WORLD_WIDTH_RESET  = WORLD_BITS'(262144);
   localparam logic [WORLD_BITS-1:0] WORLD_HEIGHT_RESET = WORLD_BITS'(262144);

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WORLD_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WORLD_HEIGHT = 1'b1;

   // Child codes, added to four times the parent index.
   localparam logic [2:0] CHILD_TOP_LEFT     = 3'd1;
   localparam logic [2:0] CHILD_TOP_RIGHT    = 3'd2;
   localparam logic [2:0] CHILD_BOTTOM_RIGHT = 3'd3;
   localparam logic [2:0] CHILD_BOTTOM_LEFT  = 3'd4;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] box_low_x;
      logic signed [COORD_BITS-1:0] box_low_y;
      logic signed [COORD_BITS-1:0] box_high_x;
      logic signed [COORD_BITS-1:0] box_high_y;
      logic [TAG_BITS-1:0]          body_tag;
   } req_type;

   typedef struct packed {
      logic [NODE_INDEX_BITS-1:0] node_index;
      logic [NODE_LEVEL_BITS-1:0] node_level;
      logic [TAG_BITS-1:0]        tag_out;
   } rsp_type;

endpackage

// ===== rtl/quadtree_node_index_for_box.sv =====
// Top level of the quadtree node lookup: a pipeline with one stage per tree level.
//
//   Channel  Direction  Handshake            Moves
//   req      in         req_valid/req_stall  box bounds and body tag
//   rsp      out        rsp_valid/rsp_stall  node index, node level and tag
//   csr      in         csr_valid/csr_ready  world width or height write
//
// One transaction enters per cycle and one result leaves per cycle when the
// result side does not stall. A result passes through one input register
// stage and one stage per level on its way from its request transaction.
// Reset is synchronous; it empties the pipeline and restores the world size.
// A stall only holds stages that are full and whose successor cannot move, so
// empty stages keep filling and nothing is lost or repeated.
`include "quadtree_node_index_for_box_macros.svh"

module quadtree_node_index_for_box
   import qnib_pkg::*;
#(
   parameter int TREE_LEVELS = TREE_LEVELS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [WORLD_BITS-1:0]     csr_data
);

   // Coordinates carry TREE_LEVELS extra fraction bits so that every midpoint
   // down to the leaves is exact. One more bit keeps the world size, which is
   // narrower than a box coordinate, positive.
   localparam int VW  = COORD_BITS + TREE_LEVELS + 1;
   // The deepest index is 4 + 16 + ... + 4^TREE_LEVELS, below 2^(2L+1).
   localparam int NW  = 2 * TREE_LEVELS + 1;
   localparam int LVW = $clog2(TREE_LEVELS + 1);

   // World size registers. Writes are always taken.
   logic [WORLD_BITS-1:0] world_width_ff;
   logic [WORLD_BITS-1:0] world_height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         world_width_ff  <= WORLD_WIDTH_RESET;
         world_height_ff <= WORLD_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WORLD_WIDTH:  world_width_ff  <= csr_data;
            CSR_WORLD_HEIGHT: world_height_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Stage registers. Stage 0 holds the scaled request and the root rectangle;
   // stage s + 1 holds the node chosen after descending from level s. The last
   // stage is the output register.
   logic [TREE_LEVELS:0]    valid_ff;
   logic [TREE_LEVELS:0]    valid_in;
   logic [TREE_LEVELS:0]    done_ff;
   logic [TREE_LEVELS:0]    done_in;
   logic [TREE_LEVELS:0]    ready;
   logic [LVW-1:0]          lvl_ff  [0:TREE_LEVELS];
   logic [LVW-1:0]          lvl_in  [0:TREE_LEVELS];
   logic [NW-1:0]           node_ff [0:TREE_LEVELS];
   logic [NW-1:0]           node_in [0:TREE_LEVELS];
   logic [TAG_BITS-1:0]     tag_ff  [0:TREE_LEVELS];
   logic [TAG_BITS-1:0]     tag_in  [0:TREE_LEVELS];
   logic signed [VW-1:0]    bx0_ff  [0:TREE_LEVELS];
   logic signed [VW-1:0]    bx0_in  [0:TREE_LEVELS];
   logic signed [VW-1:0]    by0_ff  [0:TREE_LEVELS];
   logic signed [VW-1:0]    by0_in  [0:TREE_LEVELS];
   logic signed [VW-1:0]    bx1_ff  [0:TREE_LEVELS];
   logic signed [VW-1:0]    bx1_in  [0:TREE_LEVELS];
   logic signed [VW-1:0]    by1_ff  [0:TREE_LEVELS];
   logic signed [VW-1:0]    by1_in  [0:TREE_LEVELS];
   logic signed [VW-1:0]    nx0_ff  [0:TREE_LEVELS];
   logic signed [VW-1:0]    nx0_in  [0:TREE_LEVELS];
   logic signed [VW-1:0]    ny0_ff  [0:TREE_LEVELS];
   logic signed [VW-1:0]    ny0_in  [0:TREE_LEVELS];
   logic signed [VW-1:0]    nx1_ff  [0:TREE_LEVELS];
   logic signed [VW-1:0]    nx1_in  [0:TREE_LEVELS];
   logic signed [VW-1:0]    ny1_ff  [0:TREE_LEVELS];
   logic signed [VW-1:0]    ny1_in  [0:TREE_LEVELS];

   // A stage can load when it is empty or its own contents move on. The chain
   // ends at the output register, which moves when the result side takes it.
   assign ready[TREE_LEVELS] = !valid_ff[TREE_LEVELS] || !rsp_stall;

   genvar s;
   generate
      for (s = 0; s < TREE_LEVELS; s++) begin : g_ready
         assign ready[s] = !valid_ff[s] || ready[s+1];
      end
   endgenerate

   assign req_stall = !ready[0];

   // Stage 0 input: scale the box and start at the root rectangle.
   always_comb begin
      valid_in[0] = req_valid;
      done_in[0]  = 1'b0;
      lvl_in[0]   = '0;
      node_in[0]  = '0;
      tag_in[0]   = req_data.body_tag;
      bx0_in[0]   = VW'(req_data.box_low_x)  <<< TREE_LEVELS;
      by0_in[0]   = VW'(req_data.box_low_y)  <<< TREE_LEVELS;
      bx1_in[0]   = VW'(req_data.box_high_x) <<< TREE_LEVELS;
      by1_in[0]   = VW'(req_data.box_high_y) <<< TREE_LEVELS;
      nx0_in[0]   = '0;
      ny0_in[0]   = '0;
      nx1_in[0]   = VW'({world_width_ff,  {TREE_LEVELS{1'b0}}});
      ny1_in[0]   = VW'({world_height_ff, {TREE_LEVELS{1'b0}}});
   end

   // One descent step per stage. The four children are tested in parallel and
   // the first that strictly contains the box wins. Once no child contains
   // the box the item is marked done and rides through the later stages.
   generate
      for (s = 0; s < TREE_LEVELS; s++) begin : g_level
         logic [VW:0]          sum_x;
         logic [VW:0]          sum_y;
         logic signed [VW-1:0] mid_x;
         logic signed [VW-1:0] mid_y;
         logic                 hit_tl;
         logic                 hit_tr;
         logic                 hit_br;
         logic                 hit_bl;

         always_comb begin
            sum_x = {nx0_ff[s][VW-1], nx0_ff[s]} + {nx1_ff[s][VW-1], nx1_ff[s]};
            sum_y = {ny0_ff[s][VW-1], ny0_ff[s]} + {ny1_ff[s][VW-1], ny1_ff[s]};
            mid_x = sum_x[VW:1];
            mid_y = sum_y[VW:1];

            hit_tl = (bx0_ff[s] > nx0_ff[s]) && (by0_ff[s] > mid_y) &&
                     (mid_x > bx1_ff[s]) && (ny1_ff[s] > by1_ff[s]);
            hit_tr = (bx0_ff[s] > mid_x) && (by0_ff[s] > mid_y) &&
                     (nx1_ff[s] > bx1_ff[s]) && (ny1_ff[s] > by1_ff[s]);
            hit_br = (bx0_ff[s] > mid_x) && (by0_ff[s] > ny0_ff[s]) &&
                     (nx1_ff[s] > bx1_ff[s]) && (mid_y > by1_ff[s]);
            hit_bl = (bx0_ff[s] > nx0_ff[s]) && (by0_ff[s] > ny0_ff[s]) &&
                     (mid_x > bx1_ff[s]) && (mid_y > by1_ff[s]);

            valid_in[s+1] = valid_ff[s];
            done_in[s+1]  = done_ff[s];
            lvl_in[s+1]   = lvl_ff[s];
            node_in[s+1]  = node_ff[s];
            tag_in[s+1]   = tag_ff[s];
            bx0_in[s+1]   = bx0_ff[s];
            by0_in[s+1]   = by0_ff[s];
            bx1_in[s+1]   = bx1_ff[s];
            by1_in[s+1]   = by1_ff[s];
            nx0_in[s+1]   = nx0_ff[s];
            ny0_in[s+1]   = ny0_ff[s];
            nx1_in[s+1]   = nx1_ff[s];
            ny1_in[s+1]   = ny1_ff[s];

            if (!done_ff[s]) begin
               if (hit_tl) begin
                  node_in[s+1] = (node_ff[s] << 2) + NW'(CHILD_TOP_LEFT);
                  ny0_in[s+1]  = mid_y;
                  nx1_in[s+1]  = mid_x;
               end else if (hit_tr) begin
                  node_in[s+1] = (node_ff[s] << 2) + NW'(CHILD_TOP_RIGHT);
                  nx0_in[s+1]  = mid_x;
                  ny0_in[s+1]  = mid_y;
               end else if (hit_br) begin
                  node_in[s+1] = (node_ff[s] << 2) + NW'(CHILD_BOTTOM_RIGHT);
                  nx0_in[s+1]  = mid_x;
                  ny1_in[s+1]  = mid_y;
               end else if (hit_bl) begin
                  node_in[s+1] = (node_ff[s] << 2) + NW'(CHILD_BOTTOM_LEFT);
                  nx1_in[s+1]  = mid_x;
                  ny1_in[s+1]  = mid_y;
               end else begin
                  done_in[s+1] = 1'b1;
               end
               if (hit_tl || hit_tr || hit_br || hit_bl) begin
                  lvl_in[s+1] = lvl_ff[s] + LVW'(1);
               end
            end
         end
      end
   endgenerate

   // Valid bits are reset; the payload of a stage loads with it.
   generate
      for (s = 0; s <= TREE_LEVELS; s++) begin : g_stage
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[s] <= 1'b0;
            end else if (ready[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end

         always_ff @(posedge clock) begin
            if (ready[s]) begin
               done_ff[s] <= done_in[s];
               lvl_ff[s]  <= lvl_in[s];
               node_ff[s] <= node_in[s];
               tag_ff[s]  <= tag_in[s];
               bx0_ff[s]  <= bx0_in[s];
               by0_ff[s]  <= by0_in[s];
               bx1_ff[s]  <= bx1_in[s];
               by1_ff[s]  <= by1_in[s];
               nx0_ff[s]  <= nx0_in[s];
               ny0_ff[s]  <= ny0_in[s];
               nx1_ff[s]  <= nx1_in[s];
               ny1_ff[s]  <= ny1_in[s];
            end
         end
      end
   endgenerate

   // The result fields are the low bits of the final index and level.
   assign rsp_valid           = valid_ff[TREE_LEVELS];
   assign rsp_data.node_index = NODE_INDEX_BITS'(node_ff[TREE_LEVELS]);
   assign rsp_data.node_level = NODE_LEVEL_BITS'(lvl_ff[TREE_LEVELS]);
   assign rsp_data.tag_out    = tag_ff[TREE_LEVELS];

   // The root is reported exactly when no descent took place.
   `QNIB_ASSERT_IMPLY(a_root_matches_level, valid_ff[TREE_LEVELS], ((lvl_ff[TREE_LEVELS] == '0) == (node_ff[TREE_LEVELS] == '0)), "node index and level disagree on the root")

   // An item that never stopped early must have reached the leaf level.
   `QNIB_ASSERT_IMPLY(a_leaf_when_not_done, valid_ff[TREE_LEVELS] && !done_ff[TREE_LEVELS], (lvl_ff[TREE_LEVELS] == LVW'(TREE_LEVELS)), "undone item left before the leaf level")

   // The input side stalls only when the output is held and every stage is full.
   `QNIB_ASSERT_IMPLY(a_stall_only_when_full, req_stall, (rsp_valid && rsp_stall && (&valid_ff)), "request stalled with room in the pipeline")

endmodule
